### design/ota_pkg.sv
`timescale 1ns / 1ps
package ota_pkg;

  localparam int COORD_BITS = 12;
  localparam int SPAN_BITS = COORD_BITS + 1;
  localparam int AREA_BITS = 2 * COORD_BITS;
  localparam int INTER_BITS = 2 * SPAN_BITS;
  localparam int PROD_BITS = INTER_BITS + AREA_BITS;
  localparam int RATIO_BITS = 17;
  localparam int FRAC_BITS = 16;
  localparam int BOX_BITS = 4 * COORD_BITS;
  localparam logic [RATIO_BITS-1:0] THRESH_RESET = 17'd49152;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_EOF = 2'd2;

  typedef struct packed {
    logic load;
    logic rd;
    logic ovl;
    logic mul;
    logic xa;
    logic xb;
    logic upd;
    logic div_init;
    logic div_step;
    logic chk;
  } ota_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic scan_last;
    logic div_last;
    logic found;
  } ota_sts_t;

endpackage

### design/overlap_track_association.sv
`timescale 1ns / 1ps
// Track association by greedy overlap over the smaller box area.
// Command channel: an item is taken at a clock edge with start high and busy
// low; busy stays high until its result has been shown. operation selects
// write slot, query detection or end of frame; other codes only answer.
// Result channel: done is high for exactly one cycle with matched, best_slot
// and best_ratio; the receiver must take it then, it cannot stall.
// Non-query: result shows in finish state, entered from idle; fields zero.
// Query: each slot steps through one shared multiplier (read, overlap,
// area, two cross products, compare); then, if a candidate was found, a
// 16-step restoring divider forms the Q16 ratio.
// Threshold channel: cfg_valid/cfg_ready, always ready; write only while idle.
// Reset: all slots invalid and unclaimed, threshold 0.75 in Q16, idle.
// Slot boxes hold no reset value; only slots written valid are used.
module overlap_track_association
  import ota_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [3:0]            slot_index,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-1:0] box_width,
  input  logic [COORD_BITS-1:0] box_height,
  input  logic                  slot_valid,
  output logic                  done,
  output logic                  matched,
  output logic [3:0]            best_slot,
  output logic [RATIO_BITS-1:0] best_ratio,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATIO_BITS-1:0] cfg_data
);

  ota_cmd_t cmd;
  ota_sts_t sts;

  assign cfg_ready = 1'b1;

  ota_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  ota_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operation (operation),
    .slot_index(slot_index),
    .box_x     (box_x),
    .box_y     (box_y),
    .box_width (box_width),
    .box_height(box_height),
    .slot_valid(slot_valid),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .matched   (matched),
    .best_slot (best_slot),
    .best_ratio(best_ratio)
  );

endmodule

### design/ota_ctrl.sv
`timescale 1ns / 1ps
module ota_ctrl
  import ota_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ota_sts_t sts,
  output ota_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;
  localparam logic [3:0] S_OVL = 4'd2;
  localparam logic [3:0] S_MUL = 4'd3;
  localparam logic [3:0] S_XA = 4'd4;
  localparam logic [3:0] S_XB = 4'd5;
  localparam logic [3:0] S_UPD = 4'd6;
  localparam logic [3:0] S_DIVI = 4'd7;
  localparam logic [3:0] S_DIV = 4'd8;
  localparam logic [3:0] S_CHK = 4'd9;
  localparam logic [3:0] S_FIN = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = (sts.op == OP_QUERY) ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_OVL;
      end
      S_OVL: begin
        cmd.ovl = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_XA;
      end
      S_XA: begin
        cmd.xa = 1'b1;
        state_next = S_XB;
      end
      S_XB: begin
        cmd.xb = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DIVI;
        end else begin
          state_next = S_RD;
        end
      end
      S_DIVI: begin
        if (sts.found) begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN);

endmodule

### design/ota_dp.sv
`timescale 1ns / 1ps
module ota_dp
  import ota_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ota_cmd_t               cmd,
  output ota_sts_t               sts,
  input  logic [1:0]             operation,
  input  logic [3:0]             slot_index,
  input  logic [COORD_BITS-1:0]  box_x,
  input  logic [COORD_BITS-1:0]  box_y,
  input  logic [COORD_BITS-1:0]  box_width,
  input  logic [COORD_BITS-1:0]  box_height,
  input  logic                   slot_valid,
  input  logic                   cfg_valid,
  input  logic [RATIO_BITS-1:0]  cfg_data,
  output logic                   matched,
  output logic [3:0]             best_slot,
  output logic [RATIO_BITS-1:0]  best_ratio
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int REM_BITS = AREA_BITS + 1;

  logic [BOX_BITS-1:0] mem [SLOT_COUNT];
  logic [BOX_BITS-1:0] rd_q;
  logic [SLOT_COUNT-1:0] valid;
  logic [SLOT_COUNT-1:0] claimed;
  logic [RATIO_BITS-1:0] thresh;

  logic [COORD_BITS-1:0] qx, qy, qw, qh;
  logic [AREA_BITS-1:0] sd;
  logic [SW-1:0] scan;
  logic elig;
  logic [SPAN_BITS-1:0] ox, oy;
  logic [AREA_BITS-1:0] ss;
  logic [INTER_BITS-1:0] si;
  logic [AREA_BITS-1:0] sm;
  logic [PROD_BITS-1:0] p1, p2;
  logic found;
  logic [SW-1:0] best;
  logic [INTER_BITS-1:0] best_si;
  logic [AREA_BITS-1:0] best_sm;
  logic [REM_BITS-1:0] rem;
  logic [RATIO_BITS-1:0] quo;
  logic [3:0] div_cnt;

  logic [COORD_BITS-1:0] ex, ey, ew, eh;
  logic [SPAN_BITS-1:0] a1, b1, lo_x, hi_x, lo_y, hi_y, c1, d1;
  logic [INTER_BITS-1:0] mul_a;
  logic [AREA_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0] prod;
  logic [REM_BITS-1:0] rem2;
  logic [REM_BITS-1:0] si_ext, sm_ext;
  logic [SW-1:0] widx;
  logic widx_ok;

  assign {ex, ey, ew, eh} = rd_q;
  assign widx = SW'(slot_index);
  assign widx_ok = ({28'd0, slot_index} < 32'(SLOT_COUNT));

  always_comb begin
    a1 = {1'b0, qx} + {1'b0, qw};
    b1 = {1'b0, ex} + {1'b0, ew};
    lo_x = (qx > ex) ? {1'b0, qx} : {1'b0, ex};
    hi_x = (a1 < b1) ? a1 : b1;
    c1 = {1'b0, qy} + {1'b0, qh};
    d1 = {1'b0, ey} + {1'b0, eh};
    lo_y = (qy > ey) ? {1'b0, qy} : {1'b0, ey};
    hi_y = (c1 < d1) ? c1 : d1;
  end

  always_comb begin
    mul_a = INTER_BITS'(box_width);
    mul_b = AREA_BITS'(box_height);
    if (cmd.ovl) begin
      mul_a = INTER_BITS'(ew);
      mul_b = AREA_BITS'(eh);
    end else if (cmd.mul) begin
      mul_a = INTER_BITS'(ox);
      mul_b = AREA_BITS'(oy);
    end else if (cmd.xa) begin
      mul_a = si;
      mul_b = best_sm;
    end else if (cmd.xb) begin
      mul_a = best_si;
      mul_b = sm;
    end
  end

  assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  assign rem2 = {rem[REM_BITS-2:0], 1'b0};
  assign si_ext = REM_BITS'(best_si);
  assign sm_ext = REM_BITS'(best_sm);

  always_ff @(posedge clk) begin
    if (cmd.load && operation == OP_WRITE && widx_ok) begin
      mem[widx] <= {box_x, box_y, box_width, box_height};
    end
    if (cmd.rd) begin
      rd_q <= mem[scan];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      claimed <= '0;
      thresh <= THRESH_RESET;
      found <= 1'b0;
      scan <= '0;
      matched <= 1'b0;
      best_slot <= '0;
      best_ratio <= '0;
    end else begin
      if (cfg_valid) begin
        thresh <= cfg_data;
      end
      if (cmd.load) begin
        found <= 1'b0;
        scan <= '0;
        matched <= 1'b0;
        best_slot <= '0;
        best_ratio <= '0;
        if (operation == OP_WRITE && widx_ok) begin
          valid[widx] <= slot_valid;
          claimed[widx] <= 1'b0;
        end
        if (operation == OP_EOF) begin
          claimed <= '0;
        end
      end
      if (cmd.upd) begin
        if (elig && si != '0 && sm != '0 && (!found || p1 > p2)) begin
          found <= 1'b1;
        end
        scan <= scan + 1'b1;
      end
      if (cmd.chk) begin
        matched <= (quo >= thresh);
        best_slot <= 4'(best);
        best_ratio <= quo;
        if (quo >= thresh) begin
          claimed[best] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx <= box_x;
      qy <= box_y;
      qw <= box_width;
      qh <= box_height;
      sd <= prod[AREA_BITS-1:0];
      best <= '0;
      best_si <= '0;
      best_sm <= AREA_BITS'(1);
    end
    if (cmd.rd) begin
      elig <= valid[scan] & ~claimed[scan];
    end
    if (cmd.ovl) begin
      ox <= (hi_x > lo_x) ? hi_x - lo_x : '0;
      oy <= (hi_y > lo_y) ? hi_y - lo_y : '0;
      ss <= prod[AREA_BITS-1:0];
    end
    if (cmd.mul) begin
      si <= prod[INTER_BITS-1:0];
      sm <= (sd < ss) ? sd : ss;
    end
    if (cmd.xa) begin
      p1 <= prod;
    end
    if (cmd.xb) begin
      p2 <= prod;
    end
    if (cmd.upd && elig && si != '0 && sm != '0 && (!found || p1 > p2)) begin
      best <= scan;
      best_si <= si;
      best_sm <= sm;
    end
    if (cmd.div_init) begin
      div_cnt <= '0;
      if (si_ext >= sm_ext) begin
        rem <= si_ext - sm_ext;
        quo <= RATIO_BITS'(1);
      end else begin
        rem <= si_ext;
        quo <= '0;
      end
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem2 >= sm_ext) begin
        rem <= rem2 - sm_ext;
        quo <= {quo[RATIO_BITS-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[RATIO_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sts.op = operation;
    sts.scan_last = (32'(scan) == SLOT_COUNT - 1);
    sts.div_last = (div_cnt == 4'(FRAC_BITS - 1));
    sts.found = found;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ota_pkg::*;

  typedef struct {
    logic [1:0]            op;
    logic [3:0]            idx;
    logic [COORD_BITS-1:0] x, y, w, h;
    logic                  vld;
  } track_cmd_t;

  typedef struct {
    logic                  matched;
    logic [3:0]            slot;
    logic [RATIO_BITS-1:0] ratio;
  } assoc_res_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] operation = '0;
  logic [3:0] slot_index = '0;
  logic [COORD_BITS-1:0] box_x = '0, box_y = '0, box_width = '0, box_height = '0;
  logic slot_valid = 0;
  logic done, matched;
  logic [3:0] best_slot;
  logic [RATIO_BITS-1:0] best_ratio;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [RATIO_BITS-1:0] cfg_data = '0;

  overlap_track_association u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [COORD_BITS-1:0] trk_x[16], trk_y[16], trk_w[16], trk_h[16];
  logic trk_valid[16], trk_claimed[16];
  logic [RATIO_BITS-1:0] thresh;

  track_cmd_t pending_cmds[$];
  assoc_res_t expected_res[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0, n_match = 0;
  bit calm = 0;

  function automatic longint span_ovl(longint a0, longint al, longint b0, longint bl);
    longint lo, hi;
    lo = a0 > b0 ? a0 : b0;
    hi = (a0 + al) < (b0 + bl) ? (a0 + al) : (b0 + bl);
    return hi > lo ? hi - lo : 0;
  endfunction

  function automatic assoc_res_t associate(track_cmd_t c);
    assoc_res_t r;
    bit found;
    longint bsi, bsm, si, sd, ss, sm, q;
    r = '{0, 0, 0};
    found = 0;
    bsi = 0;
    bsm = 1;
    if (c.op == OP_WRITE) begin
      trk_x[c.idx] = c.x;
      trk_y[c.idx] = c.y;
      trk_w[c.idx] = c.w;
      trk_h[c.idx] = c.h;
      trk_valid[c.idx] = c.vld;
      trk_claimed[c.idx] = 0;
    end else if (c.op == OP_EOF) begin
      foreach (trk_claimed[i]) trk_claimed[i] = 0;
    end else if (c.op == OP_QUERY) begin
      for (int i = 0; i < 16; i++) begin
        if (!trk_valid[i] || trk_claimed[i]) continue;
        si = span_ovl(c.x, c.w, trk_x[i], trk_w[i]) * span_ovl(c.y, c.h, trk_y[i], trk_h[i]);
        if (si == 0) continue;
        sd = longint'(c.w) * c.h;
        ss = longint'(trk_w[i]) * trk_h[i];
        sm = sd < ss ? sd : ss;
        if (sm == 0) continue;
        if (!found || si * bsm > bsi * sm) begin
          found = 1;
          r.slot = 4'(i);
          bsi = si;
          bsm = sm;
        end
      end
      if (found) begin
        q = (bsi << 16) / bsm;
        if (q > 65536) q = 65536;
        r.ratio = RATIO_BITS'(q);
        if (q >= thresh) begin
          r.matched = 1;
          trk_claimed[r.slot] = 1;
        end
      end
    end
    return r;
  endfunction

  function automatic track_cmd_t mk(logic [1:0] op, int idx, int x, int y, int w, int h,
                                    bit v);
    track_cmd_t c;
    c.op = op; c.idx = 4'(idx); c.x = COORD_BITS'(x); c.y = COORD_BITS'(y);
    c.w = COORD_BITS'(w); c.h = COORD_BITS'(h); c.vld = v;
    return c;
  endfunction

  function automatic void enqueue_cmd(track_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic track_cmd_t rand_cmd();
    track_cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    c.idx = 4'($urandom);
    c.vld = $urandom_range(0, 9) != 0;
    if (k < 30) c.op = OP_WRITE;
    else if (k < 88) c.op = OP_QUERY;
    else if (k < 96) c.op = OP_EOF;
    else c.op = 2'd3;
    if ($urandom_range(0, 9) < 8) begin
      c.x = COORD_BITS'(100 + $urandom_range(0, 60));
      c.y = COORD_BITS'(200 + $urandom_range(0, 60));
      c.w = $urandom_range(0, 9) == 0 ? '0 : COORD_BITS'($urandom_range(1, 120));
      c.h = COORD_BITS'($urandom_range(1, 120));
    end else begin
      c.x = COORD_BITS'($urandom); c.y = COORD_BITS'($urandom);
      c.w = COORD_BITS'($urandom); c.h = COORD_BITS'($urandom);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (!(start && !busy) && start) begin
    end else if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
      track_cmd_t c;
      c = pending_cmds.pop_front();
      start <= 1;
      operation <= c.op;
      slot_index <= c.idx;
      box_x <= c.x;
      box_y <= c.y;
      box_width <= c.w;
      box_height <= c.h;
      slot_valid <= c.vld;
      expected_res = {expected_res, associate(c)};
      n_sent++;
    end else begin
      start <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      assoc_res_t e;
      n_recv++;
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t result with nothing expected: %0d %0d %0d", $time, matched, best_slot,
                 best_ratio);
      end else begin
        e = expected_res.pop_front();
        n_match += int'(matched);
        if (matched !== e.matched) begin
          errors++;
          $display("%0t matched exp %0d got %0d", $time, e.matched, matched);
        end
        if (best_slot !== e.slot) begin
          errors++;
          $display("%0t best_slot exp %0d got %0d", $time, e.slot, best_slot);
        end
        if (best_ratio !== e.ratio) begin
          errors++;
          $display("%0t best_ratio exp %0d got %0d", $time, e.ratio, best_ratio);
        end
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_res.size() > 0 || start) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_thresh(logic [RATIO_BITS-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    thresh = v;
  endtask

  initial begin
    int settings[5] = '{0, 65536, 65537, 131071, 32768};
    foreach (trk_valid[i]) begin
      trk_valid[i] = 0; trk_claimed[i] = 0;
      trk_x[i] = 0; trk_y[i] = 0; trk_w[i] = 0; trk_h[i] = 0;
    end
    thresh = THRESH_RESET;
    repeat (8) @(posedge clk);
    rst <= 0;
    enqueue_cmd(mk(OP_QUERY, 0, 10, 10, 10, 10, 1));
    enqueue_cmd(mk(OP_WRITE, 0, 0, 0, 100, 100, 1));
    enqueue_cmd(mk(OP_WRITE, 1, 0, 0, 100, 100, 1));
    enqueue_cmd(mk(OP_WRITE, 15, 4095, 4095, 4095, 4095, 1));
    enqueue_cmd(mk(OP_WRITE, 2, 50, 50, 0, 30, 1));
    enqueue_cmd(mk(OP_WRITE, 3, 0, 0, 200, 200, 0));
    enqueue_cmd(mk(OP_QUERY, 9, 0, 0, 100, 100, 0));
    enqueue_cmd(mk(OP_QUERY, 0, 0, 0, 100, 100, 1));
    enqueue_cmd(mk(OP_QUERY, 0, 0, 0, 100, 100, 1));
    enqueue_cmd(mk(OP_QUERY, 0, 90, 90, 100, 100, 1));
    enqueue_cmd(mk(OP_QUERY, 0, 4000, 4000, 4095, 4095, 1));
    enqueue_cmd(mk(OP_QUERY, 0, 60, 60, 0, 10, 1));
    enqueue_cmd(mk(2'd3, 5, 1, 1, 1, 1, 1));
    enqueue_cmd(mk(OP_EOF, 0, 0, 0, 0, 0, 0));
    enqueue_cmd(mk(OP_QUERY, 0, 20, 20, 30, 30, 0));
    enqueue_cmd(mk(OP_WRITE, 0, 0, 0, 100, 100, 0));
    for (int p = 0; p < 5; p++) begin
      set_thresh(RATIO_BITS'(settings[p]));
      calm = (p == 2);
      for (int i = 0; i < 200; i++) enqueue_cmd(rand_cmd());
    end
    drain();
    $display("Sent %0d items, checked %0d results, %0d matches, thresholds 0..max swept.",
             n_sent, n_recv, n_match);
    if (errors == 0 && expected_res.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
